>>> src/kes_pkg.sv
// ----------------------------------------------------------------------------
// kes_pkg: shared definitions for the key exchange sorter
// Port widths, parameter defaults and the controller/datapath interface.
// ----------------------------------------------------------------------------
package kes_pkg;

	localparam int KEY_W            = 32;
	localparam int IDX_W            = 6;
	localparam int MAX_ITEMS_DEF    = 64;
	localparam int KEY_BITS_DEF     = 32;

	// commands from controller to datapath, at most one high per cycle
	typedef struct packed {
		logic load;   // store an accepted word
		logic rd_i;   // read entry i, set j = i + 1
		logic get_i;  // latch entry i, read entry j
		logic scan;   // compare entry j with held entry, read next j
		logic wr_i;   // write held entry back at i, move to next i
		logic emit;   // read entry k onto the result port
	} kes_cmd_t;

	typedef struct packed {
		logic fill_empty; // no entry stored yet
		logic j_at_n;     // inner index has passed the last entry
		logic i_done;     // no pair left after the current outer index
		logic k_last;     // emitting the final entry
	} kes_sts_t;

endpackage

>>> src/key_exchange_sort.sv
// ----------------------------------------------------------------------------
// key_exchange_sort: set sorter by exchange sort
// Loads a set of keys, sorts them in place and streams them with their tags.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word is taken at a clock edge with start high and busy low.
//   Each word stores one key tagged with its arrival position; words past
//   MAX_ITEMS are dropped and set the overflowed flag of the set.
//   A word with last_item high starts the sort; busy drops in the cycle
//   that carries the last result.
//   Sorting: one shared compare unit reads at most one stored entry per cycle
//   from a single RAM, so a set of N >= 2 entries keeps busy high through the
//   exchange passes and the output after the last word. A set of one entry
//   skips the sort and goes straight to the output.
//   Output: one result per entry in sorted order, on consecutive cycles,
//   each valid for one cycle with result_strobe; end_of_run marks the last.
//   The first result comes from the registered read of the first entry after
//   the sort. The receiver cannot stall.
//   Configuration: cfg_ready is always high; write descending only while idle.
//   Reset clears the set and the descending register; the store needs no
//   clearing.
// ----------------------------------------------------------------------------
module key_exchange_sort #(
	parameter int MAX_ITEMS = kes_pkg::MAX_ITEMS_DEF,
	parameter int KEY_BITS  = kes_pkg::KEY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [kes_pkg::KEY_W-1:0]  sort_key,
	input  logic                       last_item,
	output logic                       result_strobe,
	output logic [kes_pkg::KEY_W-1:0]  sorted_key,
	output logic [kes_pkg::IDX_W-1:0]  source_index,
	output logic                       overflowed,
	output logic                       end_of_run,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data
);

	import kes_pkg::*;

	kes_cmd_t cmd;
	kes_sts_t sts;
	logic     descending_q;
	logic     ctrl_busy;

	assign cfg_ready = 1'b1;
	assign busy      = ctrl_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			descending_q <= cfg_data;
		end
	end

	kes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start && !ctrl_busy),
		.last_item(last_item),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (ctrl_busy)
	);

	kes_dp #(
		.MAX_ITEMS(MAX_ITEMS),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.descending   (descending_q),
		.sort_key     (sort_key),
		.last_item    (last_item),
		.result_strobe(result_strobe),
		.sorted_key   (sorted_key),
		.source_index (source_index),
		.overflowed   (overflowed),
		.end_of_run   (end_of_run)
	);

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_item |=> busy)
		else $error("last word did not start a sort");

	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && last_item))
		else $error("busy rose without a last word");

	a_end_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && end_of_run |=> !result_strobe)
		else $error("result after end of run");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && end_of_run |-> !busy)
		else $error("still busy at end of run");

endmodule

>>> src/kes_ram.sv
// ----------------------------------------------------------------------------
// kes_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/kes_ctrl.sv
// ----------------------------------------------------------------------------
// kes_ctrl: sequencer of the key exchange sorter
// Steps load, outer/inner exchange passes and result streaming.
// ----------------------------------------------------------------------------
module kes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              last_item,
	input  kes_pkg::kes_sts_t sts,
	output kes_pkg::kes_cmd_t cmd,
	output logic              busy
);

	import kes_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDI  = 3'd1;
	localparam logic [2:0] S_GETI = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_WRI  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_item) begin
						state_d = sts.fill_empty ? S_OUT : S_RDI;
					end
				end
			end
			S_RDI: begin
				cmd.rd_i = 1'b1;
				state_d  = S_GETI;
			end
			S_GETI: begin
				cmd.get_i = 1'b1;
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.j_at_n) begin
					state_d = S_WRI;
				end
			end
			S_WRI: begin
				cmd.wr_i = 1'b1;
				state_d  = sts.i_done ? S_OUT : S_GETI;
			end
			S_OUT: begin
				cmd.emit = 1'b1;
				if (sts.k_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/kes_dp.sv
// ----------------------------------------------------------------------------
// kes_dp: datapath of the key exchange sorter
// Entry store, fill and loop counters, held entry, compare and result register.
// ----------------------------------------------------------------------------
module kes_dp #(
	parameter int MAX_ITEMS = kes_pkg::MAX_ITEMS_DEF,
	parameter int KEY_BITS  = kes_pkg::KEY_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kes_pkg::kes_cmd_t          cmd,
	output kes_pkg::kes_sts_t          sts,
	input  logic                       descending,
	input  logic [kes_pkg::KEY_W-1:0]  sort_key,
	input  logic                       last_item,
	output logic                       result_strobe,
	output logic [kes_pkg::KEY_W-1:0]  sorted_key,
	output logic [kes_pkg::IDX_W-1:0]  source_index,
	output logic                       overflowed,
	output logic                       end_of_run
);

	import kes_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int EW = KEY_BITS + IDX_W;

	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic [CW-1:0] n_q;
	logic [AW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [AW-1:0] k_q;
	logic [EW-1:0] held_q;
	logic [AW-1:0] j_s1;
	logic          strobe_s1;
	logic          ovf_s1;
	logic          end_s1;

	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic          re;
	logic [AW-1:0] raddr;
	logic [EW-1:0] rdata;

	logic [KEY_BITS-1:0] rkey;
	logic [KEY_BITS-1:0] hkey;
	logic                swap;
	logic                j_lt_n;
	logic                has_room;

	kes_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rkey     = rdata[EW-1:IDX_W];
	assign hkey     = held_q[EW-1:IDX_W];
	assign swap     = descending ? (rkey > hkey) : (rkey < hkey);
	assign j_lt_n   = (j_q < n_q);
	assign has_room = (fill_q < CW'(MAX_ITEMS));

	assign sts.fill_empty = (fill_q == '0);
	assign sts.j_at_n     = !j_lt_n;
	assign sts.i_done     = ((CW + 1)'(i_q) + (CW + 1)'(2)) >= (CW + 1)'(n_q);
	assign sts.k_last     = (CW'(k_q) + CW'(1)) == n_q;

	always_comb begin
		we    = 1'b0;
		waddr = j_s1;
		wdata = held_q;
		re    = 1'b0;
		raddr = j_q[AW-1:0];
		if (cmd.load) begin
			we    = has_room;
			waddr = fill_q[AW-1:0];
			wdata = {KEY_BITS'(sort_key), IDX_W'(fill_q)};
		end
		if (cmd.rd_i) begin
			re    = 1'b1;
			raddr = i_q;
		end
		if (cmd.get_i) begin
			re = 1'b1;
		end
		if (cmd.scan) begin
			we = swap;
			re = j_lt_n;
		end
		if (cmd.wr_i) begin
			we    = 1'b1;
			waddr = i_q;
			re    = !sts.i_done;
			raddr = i_q + AW'(1);
		end
		if (cmd.emit) begin
			re    = 1'b1;
			raddr = k_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			ovf_q     <= 1'b0;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= cmd.emit;
			if (cmd.load) begin
				if (has_room) begin
					fill_q <= fill_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				if (last_item) begin
					n_q <= has_room ? fill_q + CW'(1) : fill_q;
					i_q <= '0;
					k_q <= '0;
				end
			end
			if (cmd.rd_i) begin
				j_q <= CW'(i_q) + CW'(1);
			end
			if (cmd.get_i || (cmd.scan && j_lt_n)) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.wr_i) begin
				i_q <= i_q + AW'(1);
				j_q <= CW'(i_q) + CW'(2);
			end
			if (cmd.emit) begin
				k_q <= k_q + AW'(1);
				if (sts.k_last) begin
					fill_q <= '0;
					ovf_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.get_i || (cmd.scan && swap)) begin
			held_q <= rdata;
		end
		if (cmd.get_i || (cmd.scan && j_lt_n)) begin
			j_s1 <= j_q[AW-1:0];
		end
		if (cmd.emit) begin
			ovf_s1 <= ovf_q;
			end_s1 <= sts.k_last;
		end
	end

	assign result_strobe = strobe_s1;
	assign sorted_key    = KEY_W'(rdata[EW-1:IDX_W]);
	assign source_index  = rdata[IDX_W-1:0];
	assign overflowed    = ovf_s1;
	assign end_of_run    = end_s1;

endmodule
